[hw/rtl/kdsa_pkg.sv]
// Shared types, constants and saturation helper for the scatter-accumulate block.
package kdsa_pkg;

  localparam int ACC_DEPTH = 4096;
  localparam int IDX_W = 12;
  localparam int ACC_W = 48;
  localparam int SMP_W = 16;
  localparam int WGT_W = 16;
  localparam int COEFF_PORTS = 4;

  typedef struct packed {
    logic mul;
    logic acc;
    logic sc_lo;
    logic sc_hi;
    logic sc_fin;
  } lane_ctrl_t;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/kdsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kdsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/kdsa_lane.sv]
// One compartment lane: multiply-accumulate of the dot product and weight scaling.
module kdsa_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kdsa_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [kdsa_pkg::SMP_W-1:0]    sample,
  input  logic signed [kdsa_pkg::SMP_W-1:0]    coeff,
  input  logic [kdsa_pkg::WGT_W-1:0]           weight,
  output logic signed [kdsa_pkg::ACC_W-1:0]    scaled
);
  import kdsa_pkg::*;

  logic signed [2*SMP_W-1:0] prod;
  logic signed [ACC_W-1:0]   sum;
  logic [39:0]               pp_lo;
  logic signed [40:0]        pp_hi;
  logic signed [65:0]        total;
  logic signed [65:0]        shr;
  logic signed [ACC_W-1:0]   scaled_next;

  always_comb begin
    total = (66'(pp_hi) <<< 24) + $signed({26'b0, pp_lo}) + 66'sd128;
    shr = total >>> 8;
    if (!((&shr[65:ACC_W-1]) || (~|shr[65:ACC_W-1]))) begin
      scaled_next = shr[65] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      scaled_next = shr[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= sat48((ACC_W+1)'(sum) + (ACC_W+1)'(prod));
    end else if (ctrl.sc_fin) begin
      sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= sample * coeff;
    end
    if (ctrl.sc_lo) begin
      pp_lo <= sum[23:0] * weight;
    end
    if (ctrl.sc_hi) begin
      pp_hi <= $signed(sum[ACC_W-1:24]) * $signed({1'b0, weight});
    end
    if (ctrl.sc_fin) begin
      scaled <= scaled_next;
    end
  end

endmodule

[hw/rtl/kernel_dot_scatter_accumulate.sv]
// Top level: lanes, scatter merge into the accumulator store, read-back and register port.
// A product element passes through S_MUL and S_ACC before tready returns; a segment end
// adds weight scaling (S_SLO, S_SHI, S_SFIN) and an S_RD/S_WR read-modify-write of the
// accumulator store per active lane. A read item is looked up in the store while idle and
// waits in S_QWAIT for a free output, then registers its result and frees the input.
// After reset the 4096-entry store is cleared one entry a cycle with tready low.
// active_lanes resets to 1, running sums to zero.
module kernel_dot_scatter_accumulate #(
  parameter int LANES = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample, coeff_lane0, coeff_lane1, coeff_lane2, coeff_lane3, seg_weight,
  // dest_index, lane_stride
  input  logic [119:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_index, read_value, zero fill
  output logic [63:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import kdsa_pkg::*;

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_ACC   = 10'b0000001000,
    S_SLO   = 10'b0000010000,
    S_SHI   = 10'b0000100000,
    S_SFIN  = 10'b0001000000,
    S_RD    = 10'b0010000000,
    S_WR    = 10'b0100000000,
    S_QWAIT = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [2:0]                active_lanes;
  logic [LANE_W-1:0]         n_m1;
  logic signed [SMP_W-1:0]   it_sample;
  logic signed [SMP_W-1:0]   it_coeff [COEFF_PORTS];
  logic [WGT_W-1:0]          it_weight;
  logic [IDX_W-1:0]          it_dest;
  logic [IDX_W-1:0]          it_stride;
  logic                      it_last;
  logic [IDX_W-1:0]          clr_addr;
  logic [IDX_W-1:0]          addr_cur;
  logic [LANE_W-1:0]         lane;
  lane_ctrl_t                lctrl;
  logic signed [ACC_W-1:0]   scaled [LANES];
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [ACC_W-1:0]          ram_wdata;
  logic [IDX_W-1:0]          ram_raddr;
  logic [ACC_W-1:0]          ram_rdata;
  logic [IDX_W-1:0]          out_index;
  logic [ACC_W-1:0]          out_value;
  logic                      in_xfer;
  logic                      cfg_wr;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign pready = 1'b1;
  assign prdata = {29'b0, active_lanes};
  assign cfg_wr = psel && penable && pwrite && pready;
  assign m_axis_tdata = {4'b0, out_value, out_index};

  always_comb begin
    if (active_lanes == 3'd0) begin
      n_m1 = '0;
    end else if (active_lanes > 3'(LANES)) begin
      n_m1 = LANE_W'(LANES - 1);
    end else begin
      n_m1 = LANE_W'(active_lanes - 3'd1);
    end
  end

  assign lctrl.mul = (state == S_MUL);
  assign lctrl.acc = (state == S_ACC);
  assign lctrl.sc_lo = (state == S_SLO);
  assign lctrl.sc_hi = (state == S_SHI);
  assign lctrl.sc_fin = (state == S_SFIN);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kdsa_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lctrl),
      .sample (it_sample),
      .coeff  (it_coeff[g]),
      .weight (it_weight),
      .scaled (scaled[g])
    );
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = addr_cur;
    ram_wdata = sat48((ACC_W+1)'($signed(ram_rdata)) + (ACC_W+1)'(scaled[lane]));
    if (state == S_RD) begin
      ram_raddr = addr_cur;
    end else if (state == S_IDLE) begin
      ram_raddr = s_axis_tdata[107:96];
    end else begin
      ram_raddr = it_dest;
    end
    if (state == S_CLR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_WR) begin
      ram_we = 1'b1;
    end
  end

  kdsa_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (&clr_addr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_next = s_axis_tuser ? S_QWAIT : S_MUL;
      end
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = it_last ? S_SLO : S_IDLE;
      S_SLO:  state_next = S_SHI;
      S_SHI:  state_next = S_SFIN;
      S_SFIN: state_next = S_RD;
      S_RD:   state_next = S_WR;
      S_WR: begin
        state_next = (lane == n_m1) ? S_IDLE : S_RD;
      end
      S_QWAIT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      active_lanes <= 3'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + 1'b1;
      if (cfg_wr && !paddr[2]) active_lanes <= pwdata[2:0];
      if (state == S_QWAIT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_sample <= s_axis_tdata[15:0];
      it_coeff[0] <= s_axis_tdata[31:16];
      it_coeff[1] <= s_axis_tdata[47:32];
      it_coeff[2] <= s_axis_tdata[63:48];
      it_coeff[3] <= s_axis_tdata[79:64];
      it_weight <= s_axis_tdata[95:80];
      it_dest <= s_axis_tdata[107:96];
      it_stride <= s_axis_tdata[119:108];
      it_last <= s_axis_tlast;
    end
    if (state == S_SFIN) begin
      addr_cur <= it_dest;
      lane <= '0;
    end else if (state == S_WR) begin
      addr_cur <= IDX_W'(addr_cur + it_stride);
      lane <= LANE_W'(lane + 1'b1);
    end
    if (state == S_QWAIT && (!m_axis_tvalid || m_axis_tready)) begin
      out_index <= it_dest;
      out_value <= ram_rdata;
    end
  end

endmodule
